### rtl/core/plr_pkg.sv
// Shared constants, widths and the arctangent table for the polyline resampler.
// No dependencies; imported by every module of the core.
package plr_pkg;

    localparam int COORD_W      = 32;   // Q23.8 coordinates
    localparam int DIFF_W       = 33;   // vertex difference
    localparam int SP_W         = 16;   // spacing register
    localparam int LEN_W        = 33;   // segment length
    localparam int KAPPA_W      = 32;   // Q15.16 curvature
    localparam int MAX_STEPS    = 30;   // point cap per segment
    localparam int STEP_W       = 5;

    localparam int MUL_W        = 32;
    localparam int MUL_CNT_W    = 5;
    localparam int DIVD_W       = 48;
    localparam int DIVS_W       = 33;
    localparam int DIV_CNT_W    = 6;
    localparam int SQ_IN_W      = 66;
    localparam int SQ_ROOT_W    = 33;
    localparam int SQ_REM_W     = 36;
    localparam int SQ_CNT_W     = 6;

    localparam int HEAD_W       = 21;   // Q.16 heading
    localparam int CORDIC_W     = 40;
    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_IDX_W = 5;
    localparam int PI_Q16       = 205887;

    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REM_EN  = 1'b1;
    localparam logic [SP_W-1:0]      SPACING_RST = 16'd128;

    // rounded atan(2^-i) in Q.16
    function automatic logic [15:0] atan_q16(input logic [CORDIC_IDX_W-1:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/polyline_resampler_with_curvature_core.sv
// Polyline resampler with per-segment curvature. Vertices arrive in travel order
// (Q23.8 metres); once three are known the segment between the older two is cut into
// points at the programmed spacing, at most 30 plus an optional remainder point, each
// tagged with the segment curvature (heading change over segment length, Q15.16 per
// metre). A final vertex flushes the pending segment, the last segment and the end
// point, then restarts the path. One vertex is handled at a time. Each segment costs
// two squarings in the serial multiplier and a root in the root unit, a count division,
// and when it has points two more multiply/divide pairs before its points leave at one
// per cycle while the output is not stalled. The curvature of the older segment adds
// two CORDIC headings and one more division. Plain vertices that close no segment
// only pass through S_DONE back to idle.
// Depends on plr_pkg, plr_mul, plr_div, plr_sqrt and plr_cordic.
module polyline_resampler_with_curvature_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // vertex input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [plr_pkg::COORD_W-1:0]  i_vertex_x,
    input  logic signed [plr_pkg::COORD_W-1:0]  i_vertex_y,
    input  logic                                i_final_vertex,
    // point output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [plr_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [plr_pkg::COORD_W-1:0]  o_point_y,
    output logic signed [plr_pkg::KAPPA_W-1:0]  o_curvature,
    output logic                                o_capped,
    output logic                                o_run_end,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [plr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [plr_pkg::SP_W-1:0]            i_cfg_data
);
    import plr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_H2,
        S_H1,
        S_KDIV,
        S_NDIV,
        S_KX,
        S_QX,
        S_KY,
        S_QY,
        S_EMIT,
        S_END,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_go;       // unit launched in this state

    // path state and configuration
    logic [COORD_W-1:0]         r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic [1:0]                 r_seen;
    logic [SP_W-1:0]            r_spacing;
    logic                       r_rem_en;

    // current vertex
    logic [COORD_W-1:0]         r_vx, r_vy;
    logic                       r_final;

    // current segment
    logic                       r_seg_a;    // segment older->newer
    logic [COORD_W-1:0]         r_ax, r_ay;
    logic signed [DIFF_W-1:0]   r_dx, r_dy;
    logic [LEN_W-1:0]           r_len;
    logic [2*MUL_W-1:0]         r_sqx;
    logic signed [HEAD_W-1:0]   r_h2;
    logic signed [HEAD_W:0]     r_dth;
    logic signed [KAPPA_W-1:0]  r_kappa;
    logic                       r_capped;
    logic [STEP_W-1:0]          r_last, r_j;
    logic [MUL_W-1:0]           r_stq_x, r_stq_y, r_qx, r_qy;
    logic [LEN_W-1:0]           r_str_x, r_str_y, r_rx, r_ry;

    // output register
    logic                       r_out_valid;
    logic [COORD_W-1:0]         r_px, r_py;
    logic signed [KAPPA_W-1:0]  r_pk;
    logic                       r_pcap, r_pend;

    // unit hookup
    logic                       mul_start, mul_done;
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [2*MUL_W-1:0]         mul_prod;
    logic                       div_start, div_done;
    logic [DIVD_W-1:0]          div_dvd, div_quo;
    logic [DIVS_W-1:0]          div_dvs, div_rem;
    logic                       sq_start, sq_done;
    logic [SQ_IN_W-1:0]         sq_in;
    logic [SQ_ROOT_W-1:0]       sq_root;
    logic                       cd_start, cd_done;
    logic signed [DIFF_W-1:0]   cd_x, cd_y;
    logic signed [HEAD_W-1:0]   cd_z;

    // helpers
    logic [SP_W-1:0]            sp_eff;
    logic [DIFF_W-1:0]          abs_dx, abs_dy;
    logic signed [DIFF_W-1:0]   v_dx, v_dy;
    logic [HEAD_W:0]            abs_dth;
    logic                       slot_free;
    logic                       n_capped;
    logic [STEP_W-1:0]          n_cnt;
    logic [LEN_W-1:0]           n_rem;
    logic                       n_extra;
    logic [STEP_W-1:0]          n_last;
    logic [LEN_W:0]             n_sum_x, n_sum_y;
    logic                       n_cy_x, n_cy_y;
    logic [DIFF_W-1:0]          n_off_x, n_off_y;
    logic                       n_seg_over;

    assign sp_eff  = (r_spacing == '0) ? SP_W'(1) : r_spacing;
    assign abs_dx  = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign abs_dy  = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign v_dx    = $signed({r_vx[COORD_W-1], r_vx}) - $signed({r_newer_x[COORD_W-1], r_newer_x});
    assign v_dy    = $signed({r_vy[COORD_W-1], r_vy}) - $signed({r_newer_y[COORD_W-1], r_newer_y});
    assign abs_dth = r_dth[HEAD_W] ? (HEAD_W+1)'(-r_dth) : (HEAD_W+1)'(r_dth);
    assign slot_free = !r_out_valid || !i_out_stall;

    // point count, remainder test; capped count leaves len - 30*spacing
    assign n_capped = (div_quo[DIVD_W-1:STEP_W] != '0) ||
                      (div_quo[STEP_W-1:0] > STEP_W'(MAX_STEPS));
    assign n_cnt    = n_capped ? STEP_W'(MAX_STEPS) : div_quo[STEP_W-1:0];
    assign n_rem    = n_capped ? (r_len - LEN_W'(MAX_STEPS) * LEN_W'(sp_eff)) : div_rem;
    assign n_extra  = r_rem_en &&
                      (({3'b000, n_rem} << 2) + {3'b000, n_rem} > (LEN_W+3)'({sp_eff, 1'b0}));
    assign n_last   = n_cnt + STEP_W'(n_extra);

    // running quotient/remainder of j*spacing*|d| / len
    assign n_sum_x = {1'b0, r_rx} + {1'b0, r_str_x};
    assign n_sum_y = {1'b0, r_ry} + {1'b0, r_str_y};
    assign n_cy_x  = n_sum_x >= {1'b0, r_len};
    assign n_cy_y  = n_sum_y >= {1'b0, r_len};
    assign n_off_x = r_dx[DIFF_W-1] ? DIFF_W'(-{1'b0, r_qx}) : DIFF_W'({1'b0, r_qx});
    assign n_off_y = r_dy[DIFF_W-1] ? DIFF_W'(-{1'b0, r_qy}) : DIFF_W'({1'b0, r_qy});
    assign n_seg_over = (r_j == r_last - 1'b1);

    // unit launches: one start pulse on the first cycle of each unit state
    assign mul_start = !r_go && (r_state == S_SQX || r_state == S_SQY ||
                                 r_state == S_KX  || r_state == S_KY);
    assign div_start = !r_go && (r_state == S_KDIV || r_state == S_NDIV ||
                                 r_state == S_QX   || r_state == S_QY);
    assign sq_start  = !r_go && (r_state == S_SQRT);
    assign cd_start  = !r_go && (r_state == S_H2 || r_state == S_H1);

    always_comb begin
        mul_a = abs_dx[MUL_W-1:0];
        mul_b = abs_dx[MUL_W-1:0];
        unique case (r_state)
            S_SQY:   begin mul_a = abs_dy[MUL_W-1:0]; mul_b = abs_dy[MUL_W-1:0]; end
            S_KX:    mul_a = MUL_W'(sp_eff);
            S_KY:    begin mul_a = MUL_W'(sp_eff); mul_b = abs_dy[MUL_W-1:0]; end
            default: ;
        endcase
    end

    always_comb begin
        div_dvd = DIVD_W'(r_len);
        div_dvs = DIVS_W'(sp_eff);
        unique case (r_state)
            S_KDIV:  begin div_dvd = DIVD_W'({abs_dth, 8'h00}); div_dvs = r_len; end
            S_QX,
            S_QY:    begin div_dvd = mul_prod[DIVD_W-1:0]; div_dvs = r_len; end
            default: ;
        endcase
    end

    assign sq_in = SQ_IN_W'(r_sqx) + SQ_IN_W'(mul_prod);
    assign cd_x  = (r_state == S_H2) ? v_dx : r_dx;
    assign cd_y  = (r_state == S_H2) ? v_dy : r_dy;

    plr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    plr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    plr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_in),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    plr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_x     (cd_x),
        .i_y     (cd_y),
        .o_done  (cd_done),
        .o_z     (cd_z)
    );

    // sequencer, path state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_older_x   <= '0;
            r_older_y   <= '0;
            r_newer_x   <= '0;
            r_newer_y   <= '0;
            r_seen      <= '0;
            r_spacing   <= SPACING_RST;
            r_rem_en    <= 1'b1;
            r_out_valid <= 1'b0;
            r_j         <= '0;
            r_last      <= '0;
        end else begin
            if (mul_start || div_start || sq_start || cd_start)
                r_go <= 1'b1;
            if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SPACING: r_spacing <= i_cfg_data;
                    CFG_REM_EN:  r_rem_en  <= i_cfg_data[0];
                    default:     ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_vx    <= i_vertex_x;
                        r_vy    <= i_vertex_y;
                        r_final <= i_final_vertex;
                        r_kappa <= '0;
                        if (r_seen == 2'd2) begin
                            r_seg_a <= 1'b1;
                            r_ax    <= r_older_x;
                            r_ay    <= r_older_y;
                            r_dx    <= $signed({r_newer_x[COORD_W-1], r_newer_x}) -
                                       $signed({r_older_x[COORD_W-1], r_older_x});
                            r_dy    <= $signed({r_newer_y[COORD_W-1], r_newer_y}) -
                                       $signed({r_older_y[COORD_W-1], r_older_y});
                            r_state <= S_SQX;
                        end else if (i_final_vertex && r_seen == 2'd1) begin
                            r_seg_a <= 1'b0;
                            r_ax    <= r_newer_x;
                            r_ay    <= r_newer_y;
                            r_dx    <= $signed({i_vertex_x[COORD_W-1], i_vertex_x}) -
                                       $signed({r_newer_x[COORD_W-1], r_newer_x});
                            r_dy    <= $signed({i_vertex_y[COORD_W-1], i_vertex_y}) -
                                       $signed({r_newer_y[COORD_W-1], r_newer_y});
                            r_state <= S_SQX;
                        end else if (i_final_vertex) begin
                            r_state <= S_END;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SQX: begin
                    if (mul_done) begin
                        r_sqx   <= mul_prod;
                        r_go    <= 1'b0;
                        r_state <= S_SQY;
                    end
                end
                S_SQY: begin
                    if (mul_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_len <= sq_root;
                        r_go  <= 1'b0;
                        // zero-length first segment keeps curvature zero
                        if (r_seg_a && sq_root != '0)
                            r_state <= S_H2;
                        else
                            r_state <= S_NDIV;
                    end
                end
                S_H2: begin
                    if (cd_done) begin
                        r_h2    <= cd_z;
                        r_go    <= 1'b0;
                        r_state <= S_H1;
                    end
                end
                S_H1: begin
                    if (cd_done) begin
                        r_dth   <= (HEAD_W+1)'(r_h2) - (HEAD_W+1)'(cd_z);
                        r_go    <= 1'b0;
                        r_state <= S_KDIV;
                    end
                end
                S_KDIV: begin
                    if (div_done) begin
                        r_kappa <= r_dth[HEAD_W] ? KAPPA_W'(-div_quo[KAPPA_W-1:0])
                                                 : KAPPA_W'(div_quo[KAPPA_W-1:0]);
                        r_go    <= 1'b0;
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (div_done) begin
                        r_go     <= 1'b0;
                        r_capped <= n_capped;
                        r_last   <= n_last;
                        if (n_last == '0) begin
                            if (r_seg_a && r_final) begin
                                r_seg_a <= 1'b0;
                                r_ax    <= r_newer_x;
                                r_ay    <= r_newer_y;
                                r_dx    <= v_dx;
                                r_dy    <= v_dy;
                                r_state <= S_SQX;
                            end else if (r_seg_a) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_END;
                            end
                        end else begin
                            r_state <= S_KX;
                        end
                    end
                end
                S_KX: begin
                    if (mul_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_QX;
                    end
                end
                S_QX: begin
                    if (div_done) begin
                        r_stq_x <= div_quo[MUL_W-1:0];
                        r_str_x <= div_rem;
                        r_go    <= 1'b0;
                        r_state <= S_KY;
                    end
                end
                S_KY: begin
                    if (mul_done) begin
                        r_go    <= 1'b0;
                        r_state <= S_QY;
                    end
                end
                S_QY: begin
                    if (div_done) begin
                        r_stq_y <= div_quo[MUL_W-1:0];
                        r_str_y <= div_rem;
                        r_go    <= 1'b0;
                        r_j     <= '0;
                        r_qx    <= '0;
                        r_qy    <= '0;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_px        <= COORD_W'(DIFF_W'({r_ax[COORD_W-1], r_ax}) + n_off_x);
                        r_py        <= COORD_W'(DIFF_W'({r_ay[COORD_W-1], r_ay}) + n_off_y);
                        r_pk        <= r_kappa;
                        r_pcap      <= r_capped;
                        r_pend      <= r_seg_a && !r_final && n_seg_over;
                        r_j         <= r_j + 1'b1;
                        r_qx        <= r_qx + r_stq_x + MUL_W'(n_cy_x);
                        r_qy        <= r_qy + r_stq_y + MUL_W'(n_cy_y);
                        r_rx        <= n_cy_x ? LEN_W'(n_sum_x - {1'b0, r_len}) : LEN_W'(n_sum_x);
                        r_ry        <= n_cy_y ? LEN_W'(n_sum_y - {1'b0, r_len}) : LEN_W'(n_sum_y);
                        if (n_seg_over) begin
                            if (r_seg_a && r_final) begin
                                r_seg_a <= 1'b0;
                                r_ax    <= r_newer_x;
                                r_ay    <= r_newer_y;
                                r_dx    <= v_dx;
                                r_dy    <= v_dy;
                                r_state <= S_SQX;
                            end else if (r_seg_a) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_END;
                            end
                        end
                    end
                end
                S_END: begin
                    // end point closes the path
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_px        <= r_vx;
                        r_py        <= r_vy;
                        r_pk        <= r_kappa;
                        r_pcap      <= 1'b0;
                        r_pend      <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_older_x <= r_newer_x;
                    r_older_y <= r_newer_y;
                    r_newer_x <= r_vx;
                    r_newer_y <= r_vy;
                    if (r_final)
                        r_seen <= '0;
                    else if (r_seen != 2'd2)
                        r_seen <= r_seen + 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_curvature = r_pk;
    assign o_capped    = r_pcap;
    assign o_run_end   = r_pend;

`ifndef ASSERT_OFF
    // an accepted vertex always moves the core out of idle in the next cycle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("vertex transfer did not start processing");

    // point counter stays inside the segment's point count
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_j < r_last && r_last <= STEP_W'(MAX_STEPS + 1)))
        else $error("point index past segment end");

    // vertex count saturates at two
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("vertex count out of range");
`endif

endmodule

### rtl/core/plr_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on plr_pkg.
module plr_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [plr_pkg::MUL_W-1:0]      i_a,
    input  logic [plr_pkg::MUL_W-1:0]      i_b,
    output logic                           o_done,
    output logic [2*plr_pkg::MUL_W-1:0]    o_prod
);
    import plr_pkg::*;

    logic [MUL_W-1:0]     r_a;
    logic [MUL_W-1:0]     r_b;
    logic [2*MUL_W-1:0]   r_acc;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_W:0]       n_sum;

    assign n_sum = {1'b0, r_acc[2*MUL_W-1:MUL_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
            r_cnt  <= MUL_CNT_W'(MUL_W - 1);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_acc <= {n_sum, r_acc[MUL_W-1:1]};
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/core/plr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plr_pkg.
module plr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plr_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [plr_pkg::DIVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [plr_pkg::DIVD_W-1:0]    o_quo,
    output logic [plr_pkg::DIVS_W-1:0]    o_rem
);
    import plr_pkg::*;

    logic [DIVD_W-1:0]    r_q;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVS_W:0]      n_trial;
    logic                 n_fit;

    assign n_trial = {r_rem, r_q[DIVD_W-1]};
    assign n_fit   = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_cnt  <= DIV_CNT_W'(DIVD_W - 1);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= n_fit ? DIVS_W'(n_trial - {1'b0, r_div}) : n_trial[DIVS_W-1:0];
            r_q   <= {r_q[DIVD_W-2:0], n_fit};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule

### rtl/core/plr_sqrt.sv
// Digit-by-digit integer square root, one root bit (two radicand bits) per cycle.
// Depends on plr_pkg.
module plr_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [plr_pkg::SQ_IN_W-1:0]      i_radicand,
    output logic                             o_done,
    output logic [plr_pkg::SQ_ROOT_W-1:0]    o_root
);
    import plr_pkg::*;

    logic [SQ_IN_W-1:0]   r_in;
    logic [SQ_REM_W-1:0]  r_rem;
    logic [SQ_ROOT_W-1:0] r_root;
    logic [SQ_CNT_W-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [SQ_REM_W-1:0]  n_trial;
    logic [SQ_REM_W-1:0]  n_cand;
    logic                 n_fit;

    assign n_trial = {r_rem[SQ_REM_W-3:0], r_in[SQ_IN_W-1 -: 2]};
    assign n_cand  = SQ_REM_W'({r_root, 2'b01});
    assign n_fit   = n_trial >= n_cand;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_in   <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= SQ_CNT_W'(SQ_ROOT_W - 1);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_in   <= {r_in[SQ_IN_W-3:0], 2'b00};
            r_rem  <= n_fit ? (n_trial - n_cand) : n_trial;
            r_root <= {r_root[SQ_ROOT_W-2:0], n_fit};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/core/plr_cordic.sv
// Vectoring CORDIC heading unit: pre-scaling by doubling, then one rotation per cycle.
// Depends on plr_pkg (widths, pi, arctangent table).
module plr_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [plr_pkg::DIFF_W-1:0]   i_x,
    input  logic signed [plr_pkg::DIFF_W-1:0]   i_y,
    output logic                                o_done,
    output logic signed [plr_pkg::HEAD_W-1:0]   o_z
);
    import plr_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ITER
    } t_cstate;

    localparam logic signed [CORDIC_W-1:0] NORM_LIM = CORDIC_W'(64'sh8000_0000);

    t_cstate                     r_state;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic signed [HEAD_W-1:0]    r_z;
    logic [CORDIC_IDX_W-1:0]     r_i;
    logic                        r_done;

    logic signed [CORDIC_W-1:0]  n_xs;
    logic signed [CORDIC_W-1:0]  n_ys;
    logic signed [CORDIC_W-1:0]  n_ax;
    logic signed [CORDIC_W-1:0]  n_ay;
    logic signed [CORDIC_W-1:0]  n_sx;
    logic signed [CORDIC_W-1:0]  n_sy;
    logic signed [HEAD_W-1:0]    n_at;

    assign n_xs = CORDIC_W'(i_x);
    assign n_ys = CORDIC_W'(i_y);
    assign n_ax = r_x[CORDIC_W-1] ? -r_x : r_x;
    assign n_ay = r_y[CORDIC_W-1] ? -r_y : r_y;
    assign n_sx = r_x >>> r_i;
    assign n_sy = r_y >>> r_i;
    assign n_at = $signed(HEAD_W'(atan_q16(r_i)));

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_i <= '0;
                        if (i_x == '0 && i_y == '0) begin
                            r_z    <= '0;
                            r_done <= 1'b1;
                        end else begin
                            if (i_x < 0) begin
                                r_x <= -n_xs;
                                r_y <= -n_ys;
                                r_z <= (i_y >= 0) ? HEAD_W'(PI_Q16) : HEAD_W'(-PI_Q16);
                            end else begin
                                r_x <= n_xs;
                                r_y <= n_ys;
                                r_z <= '0;
                            end
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (n_ax < NORM_LIM && n_ay < NORM_LIM) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    // y already zero: the rotation is frozen
                    if (r_y > 0) begin
                        r_x <= r_x + n_sy;
                        r_y <= r_y - n_sx;
                        r_z <= r_z + n_at;
                    end else if (r_y < 0) begin
                        r_x <= r_x - n_sy;
                        r_y <= r_y + n_sx;
                        r_z <= r_z - n_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

### tb/tb_top.sv
// Self-checking testbench for polyline_resampler_with_curvature_core: vertex paths in,
// resampled points out, each transfer checked against an in-bench point predictor.
// Depends on plr_pkg and the core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import plr_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      fin;
        bit                        hold;   // wait for every outstanding point first
    } t_vertex;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [KAPPA_W-1:0] kappa;
        logic                      capped;
        logic                      run_end;
    } t_point;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_vertex_x = '0;
    logic signed [COORD_W-1:0] i_vertex_y = '0;
    logic                      i_final_vertex = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [COORD_W-1:0] o_point_x;
    logic signed [COORD_W-1:0] o_point_y;
    logic signed [KAPPA_W-1:0] o_curvature;
    logic                      o_capped;
    logic                      o_run_end;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [SP_W-1:0]           i_cfg_data = '0;

    polyline_resampler_with_curvature_core i_dut (.*);

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pending vertices, points still owed by the core, mismatch count
    t_vertex pending_vertices[$];
    t_point  owed_points[$];
    int      n_errors = 0;

    // Idling: 0 = sender 31 %, receiver 80 %; 1 = the reverse; 2 = no idling
    int idle_mode = 0;

    // Predictor copy of the core state and registers
    logic signed [COORD_W-1:0] pr_old_x = '0, pr_old_y = '0, pr_new_x = '0, pr_new_y = '0;
    int                        pr_seen = 0;
    logic [SP_W-1:0]           pr_spacing = SPACING_RST;
    logic                      pr_rem_en = 1'b1;

    localparam longint ATAN_TAB [CORDIC_STEPS] = '{51472, 30386, 16055, 8150, 4091,
        2047, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    // floor(sqrt(dx^2 + dy^2)); the sum needs 65 bits
    function automatic longint seg_len(longint dx, longint dy);
        logic [65:0] ax, ay, sq;
        logic [67:0] rem, cand;
        logic [33:0] root;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sq = ax * ax + ay * ay;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | sq[2*i +: 2];
            cand = {root, 2'b01};
            if (rem >= cand) begin
                rem = rem - cand;
                root = {root[32:0], 1'b1};
            end else begin
                root = {root[32:0], 1'b0};
            end
        end
        return longint'(root);
    endfunction

    // CORDIC vectoring heading, Q.16 radians
    function automatic longint heading_q16(longint x, longint y);
        longint z, m, nx;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q16 : -PI_Q16;
            x = -x;
            y = -y;
        end
        m = (x > ((y < 0) ? -y : y)) ? x : ((y < 0) ? -y : y);
        while (m < 64'sh8000_0000) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TAB[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint curvature_q16(longint ax, longint ay, longint bx, longint by,
                                             longint cx, longint cy);
        longint len, k;
        len = seg_len(bx - ax, by - ay);
        if (len == 0) return 0;
        k = ((heading_q16(cx - bx, cy - by) - heading_q16(bx - ax, by - ay)) * 256) / len;
        if (k > 64'sd2147483647) k = 64'sd2147483647;
        if (k < -64'sd2147483648) k = -64'sd2147483648;
        return k;
    endfunction

    // Points of one segment at the programmed spacing, appended to pts
    task automatic resample_segment(inout t_point pts[$], input longint ax, ay, bx, by,
                                    input longint kappa);
        longint dx, dy, len, sp, n, rem, last, d;
        t_point p;
        logic   cap;
        dx = bx - ax;
        dy = by - ay;
        len = seg_len(dx, dy);
        sp = (pr_spacing == 0) ? 1 : longint'(pr_spacing);
        n = len / sp;
        cap = 1'b0;
        if (n > MAX_STEPS) begin
            n = MAX_STEPS;
            cap = 1'b1;
        end
        rem = len - n * sp;
        last = (pr_rem_en && 5 * rem > 2 * sp) ? n + 1 : n;
        for (longint j = 0; j < last; j++) begin
            d = j * sp;
            p.x = ax + ((len != 0) ? (d * dx) / len : 0);
            p.y = ay + ((len != 0) ? (d * dy) / len : 0);
            p.kappa = kappa;
            p.capped = cap;
            p.run_end = 1'b0;
            pts = {pts, p};
        end
    endtask

    // Points one accepted vertex causes; updates the predictor state
    task automatic predict_points(input t_vertex v);
        t_point pts[$];
        t_point p;
        longint kappa;
        kappa = 0;
        if (pr_seen >= 2) begin
            kappa = curvature_q16(pr_old_x, pr_old_y, pr_new_x, pr_new_y, v.x, v.y);
            resample_segment(pts, pr_old_x, pr_old_y, pr_new_x, pr_new_y, kappa);
        end
        if (v.fin) begin
            if (pr_seen >= 1) resample_segment(pts, pr_new_x, pr_new_y, v.x, v.y, kappa);
            p.x = v.x;
            p.y = v.y;
            p.kappa = kappa;
            p.capped = 1'b0;
            p.run_end = 1'b0;
            pts = {pts, p};
            pr_seen = 0;
        end else if (pr_seen < 2) begin
            pr_seen++;
        end
        pr_old_x = pr_new_x;
        pr_old_y = pr_new_y;
        pr_new_x = v.x;
        pr_new_y = v.y;
        if (pts.size() > 0) pts[pts.size()-1].run_end = 1'b1;
        owed_points = {owed_points, pts};
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb_top: %s mismatch at %0t: got %0d, want %0d", what, $realtime, got, want);
        n_errors++;
    endtask

    // Vertex driver: one transfer per accepted edge, payload held while stalled
    always @(posedge i_clk) begin
        t_vertex v;
        bit      busy;
        bit      gap;
        busy = i_in_valid;
        if (i_in_valid && !o_in_stall) begin
            v.x = i_vertex_x;
            v.y = i_vertex_y;
            v.fin = i_final_vertex;
            predict_points(v);
            busy = 1'b0;
        end
        if (!busy) begin
            gap = (idle_mode == 0) ? ($urandom_range(0, 99) < 31) :
                  (idle_mode == 1) ? ($urandom_range(0, 99) < 80) : 1'b0;
            if (i_rst_n && !gap && pending_vertices.size() > 0 &&
                !(pending_vertices[0].hold && owed_points.size() > 0)) begin
                v = pending_vertices.pop_front();
                i_vertex_x <= v.x;
                i_vertex_y <= v.y;
                i_final_vertex <= v.fin;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Point monitor and receiver stall
    always @(posedge i_clk) begin
        t_point w;
        if (o_out_valid && !i_out_stall) begin
            if (owed_points.size() == 0) begin
                report_mismatch("unexpected point x", o_point_x, 0);
            end else begin
                w = owed_points.pop_front();
                if (o_point_x !== w.x) report_mismatch("point_x", o_point_x, w.x);
                if (o_point_y !== w.y) report_mismatch("point_y", o_point_y, w.y);
                if (o_curvature !== w.kappa) report_mismatch("curvature", o_curvature, w.kappa);
                if (o_capped !== w.capped) report_mismatch("capped", o_capped, w.capped);
                if (o_run_end !== w.run_end) report_mismatch("run_end", o_run_end, w.run_end);
            end
        end
        i_out_stall <= (idle_mode == 0) ? ($urandom_range(0, 99) < 80) :
                       (idle_mode == 1) ? ($urandom_range(0, 99) < 31) : 1'b0;
    end

    // Register write; only issued while the core is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SP_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SPACING) pr_spacing = data;
        else pr_rem_en = data[0];
    endtask

    // Wait for every queued vertex and owed point, then let a vertex that closed an
    // empty segment finish its curvature work
    task automatic drain();
        while (pending_vertices.size() > 0 || i_in_valid || owed_points.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic add_vertex(input longint x, y, input logic fin, input bit hold = 0);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.fin = fin;
        v.hold = hold;
        pending_vertices = {pending_vertices, v};
    endtask

    // Mostly well-formed paths with steps up to +/-reach; the odd vertex jumps anywhere
    logic signed [COORD_W-1:0] walk_x = '0, walk_y = '0;
    task automatic add_random_path(input int count, input int reach, input bit with_holds);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                walk_x = $urandom;
                walk_y = $urandom;
            end else begin
                walk_x = walk_x + (int'($urandom_range(0, 2 * reach)) - reach);
                walk_y = walk_y + (int'($urandom_range(0, 2 * reach)) - reach);
            end
            add_vertex(walk_x, walk_y, $urandom_range(0, 7) == 0, with_holds && (i % 10 == 9));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset registers (spacing 0.5 m, remainder on)
        idle_mode = 0;
        add_vertex(0, 0, 1);                        // final vertex alone: end point only
        add_vertex(0, 0, 0);
        add_vertex(1000, 0, 1);                     // final as second vertex
        add_vertex(5, 5, 0);
        add_vertex(5, 5, 0);                        // zero-length first segment
        add_vertex(300, 5, 0);
        add_vertex(300, 300, 1);
        add_vertex(0, 0, 0);
        add_vertex(10, 0, 0);
        add_vertex(10, 100, 0);                     // short segment, no points at all
        add_vertex(-1000, 5, 1);                    // heading swings through negative x
        add_vertex(-64'sd2147483648, -64'sd2147483648, 0);
        add_vertex(64'sd2147483647, 64'sd2147483647, 0);   // huge segment, capped
        add_vertex(64'sd2147483647, -64'sd2147483648, 0);
        add_vertex(0, 0, 1);
        add_vertex(0, 0, 0);
        add_vertex(1, 0, 0);                        // 1/256 m first segment, sharp turn
        add_vertex(-700, -3, 1);
        drain();

        // Zero spacing, no remainder point
        write_reg(CFG_SPACING, 16'd0);
        write_reg(CFG_REM_EN, 16'd0);
        add_random_path(40, 40, 0);
        drain();

        // Widest spacing, receiver mostly ready
        idle_mode = 1;
        write_reg(CFG_SPACING, 16'hFFFF);
        write_reg(CFG_REM_EN, 16'd1);
        add_random_path(40, 40 * 65535, 0);
        drain();

        // Mid spacing, no idling, sender holds off for a full drain now and then
        idle_mode = 2;
        write_reg(CFG_SPACING, 16'd300);
        add_random_path(45, 12000, 1);
        drain();

        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/core/plr_pkg.sv
rtl/core/plr_mul.sv
rtl/core/plr_div.sv
rtl/core/plr_sqrt.sv
rtl/core/plr_cordic.sv
rtl/core/polyline_resampler_with_curvature_core.sv
tb/tb_top.sv
